// File: hw/rtl/itmm_pkg.sv
// ----------------------------------------------------------------------------
// itmm_pkg
// Shared types and constants for the tile mosaic mapper: transaction
// payloads, opcodes, register indexes and the frame store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package itmm_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

   // Register and field widths
   localparam int CFG_W   = 9;
   localparam int CSR_A_W = 2;
   localparam int PIX_W   = 32;
   localparam int POS_W   = 8;

   // Divider geometry: one quotient bit per cycle
   localparam int DIV_W = 9;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Size limits in register width
   localparam logic [CFG_W-1:0] MAX_W_CFG = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] MAX_H_CFG = CFG_W'(MAX_HEIGHT);

   // Opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_TILE_FACTOR  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Request transaction
   typedef struct packed {
      logic             opcode;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] pixel_in;
   } itmm_req_type;

   // Response transaction
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             out_of_range;
   } itmm_rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/itmm_div.sv
// ----------------------------------------------------------------------------
// itmm_div
// Restoring divider that produces one quotient bit per cycle. Gives the
// quotient and remainder of two unsigned values; the divisor is never zero.
// ----------------------------------------------------------------------------
`default_nettype none

module itmm_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [itmm_pkg::DIV_W-1:0]   dividend,
   input  wire  [itmm_pkg::DIV_W-1:0]   divisor,
   output logic                         busy,
   output logic [itmm_pkg::DIV_W-1:0]   quotient,
   output logic [itmm_pkg::DIV_W-1:0]   remainder
);
   import itmm_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W+1:0] diff;

   // One trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         cnt_in = CNT_W'(DIV_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (!diff[DIV_W+1]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/itmm_axis.sv
// ----------------------------------------------------------------------------
// itmm_axis
// Maps one output coordinate along one axis to its source coordinate.
// Works out the wide tile extent and the count of wide tiles, finds the
// local offset within the tile and scales it by the tile factor.
// ----------------------------------------------------------------------------
`default_nettype none

module itmm_axis (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [itmm_pkg::POS_W-1:0]   pos,
   input  wire  [itmm_pkg::CFG_W-1:0]   size,
   input  wire  [itmm_pkg::CFG_W-1:0]   factor,
   output logic                         busy,
   output logic [itmm_pkg::POS_W-1:0]   src
);
   import itmm_pkg::*;

   localparam logic [2:0] A_IDLE  = 3'd0;
   localparam logic [2:0] A_DIV1  = 3'd1;
   localparam logic [2:0] A_MUL   = 3'd2;
   localparam logic [2:0] A_SEL   = 3'd3;
   localparam logic [2:0] A_DIV2  = 3'd4;
   localparam logic [2:0] A_SCALE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [POS_W-1:0]   pos_ff;
   logic [CFG_W-1:0]   n_ff;
   logic [CFG_W-1:0]   big_ff;
   logic [CFG_W-1:0]   spread_ff;
   logic [CFG_W-1:0]   prod_ff;
   logic [POS_W-1:0]   local_ff;
   logic [POS_W-1:0]   src_ff;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_W-1:0]   div_divisor;
   logic               div_busy;
   logic [DIV_W-1:0]   div_quo;
   logic [DIV_W-1:0]   div_rem;

   logic [2*CFG_W-1:0] prod_full;
   logic [POS_W+CFG_W-1:0] scaled;
   logic               in_wide;
   logic [CFG_W-1:0]   rest;

   itmm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Product of wide count and wide extent never exceeds the size.
   assign prod_full = (2*CFG_W)'(spread_ff) * (2*CFG_W)'(big_ff);
   assign scaled    = (POS_W+CFG_W)'(local_ff) * (POS_W+CFG_W)'(n_ff);
   assign in_wide   = ({1'b0, pos_ff} < prod_ff);
   assign rest      = {1'b0, pos_ff} - prod_ff;

   // Sequencer: size/n, then the local offset modulo the tile extent
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = size;
      div_divisor  = factor;
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               div_start = 1'b1;
               state_in  = A_DIV1;
            end
         end
         A_DIV1: begin
            if (!div_busy) begin
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            state_in = A_SEL;
         end
         A_SEL: begin
            if (in_wide) begin
               div_start    = 1'b1;
               div_dividend = {1'b0, pos_ff};
               div_divisor  = big_ff;
               state_in     = A_DIV2;
            end else if (big_ff == CFG_W'(1)) begin
               // Narrow tiles are empty: the offset is zero.
               state_in = A_SCALE;
            end else begin
               div_start    = 1'b1;
               div_dividend = rest;
               div_divisor  = big_ff - CFG_W'(1);
               state_in     = A_DIV2;
            end
         end
         A_DIV2: begin
            if (!div_busy) begin
               state_in = A_SCALE;
            end
         end
         A_SCALE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == A_IDLE && start) begin
         pos_ff <= pos;
         n_ff   <= factor;
      end
      if (state_ff == A_DIV1 && !div_busy) begin
         big_ff    <= div_quo + CFG_W'(div_rem != '0);
         spread_ff <= (div_rem == '0) ? n_ff : div_rem;
      end
      if (state_ff == A_MUL) begin
         prod_ff <= prod_full[CFG_W-1:0];
      end
      if (state_ff == A_SEL && !in_wide && big_ff == CFG_W'(1)) begin
         local_ff <= '0;
      end
      if (state_ff == A_DIV2 && !div_busy) begin
         local_ff <= div_rem[POS_W-1:0];
      end
      if (state_ff == A_SCALE) begin
         src_ff <= (scaled > (POS_W+CFG_W)'(MAX_WIDTH - 1)) ? '1 : scaled[POS_W-1:0];
      end
   end

   assign busy = (state_ff != A_IDLE);
   assign src  = src_ff;

endmodule

`default_nettype wire

// File: hw/rtl/image_tile_mosaic_mapper.sv
// ----------------------------------------------------------------------------
// image_tile_mosaic_mapper
// Tile mosaic mapper: a frame store of source pixels and a fetch path that
// returns the N x N mosaic pixel at an output coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries store and fetch transactions. A store writes
//   pixel_in into the frame store at (column, row) and produces no response.
//   A fetch produces one rsp transaction holding the mosaic pixel and an
//   out-of-range flag. A fetch inside the image maps both axes in parallel,
//   each with its own bit-serial 9-bit divider (size by factor, then offset
//   by tile extent unless the narrow tiles are empty), then reads the frame
//   store through a read register. An out-of-range fetch goes straight to
//   the output state. One transaction is in flight at a time, so a fetch
//   holds the request side until its response enters the output register.
//   The response sits in an output register; new requests are taken while
//   it waits. A fetch that finishes while the previous response is still
//   stalled holds until the receiver takes it.
//   The csr port writes tile_factor, image_width and image_height; write
//   only while idle. Reset restores the registers to 1, 256 and 256 and
//   empties the pipeline; the frame store is not cleared and an entry must
//   be stored before it is fetched.
// ----------------------------------------------------------------------------
`default_nettype none

module image_tile_mosaic_mapper (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  itmm_pkg::itmm_req_type   req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output itmm_pkg::itmm_rsp_type         rsp_data,
   input  wire                            csr_write,
   input  wire  [itmm_pkg::CSR_A_W-1:0]   csr_index,
   input  wire  [itmm_pkg::CFG_W-1:0]     csr_wdata
);
   import itmm_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_MAP  = 2'd1;
   localparam logic [1:0] T_READ = 2'd2;
   localparam logic [1:0] T_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] tile_factor_ff;
   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;

   logic [PIX_W-1:0] frame_mem [MEM_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic [PIX_W-1:0] res_pix_ff;
   logic             res_oor_ff;
   logic             rsp_valid_ff;
   itmm_rsp_type     rsp_data_ff;

   logic             req_fire;
   logic             is_store;
   logic             is_fetch;
   logic [CFG_W-1:0] eff_w;
   logic [CFG_W-1:0] eff_h;
   logic             oor;
   logic             map_start;
   logic             rd_en;
   logic             rsp_load;
   logic             x_busy;
   logic             y_busy;
   logic [POS_W-1:0] x_src;
   logic [POS_W-1:0] y_src;

   assign req_ready = (state_ff == T_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_store  = req_fire && (req_data.opcode == OP_STORE);
   assign is_fetch  = req_fire && (req_data.opcode == OP_FETCH);

   // Sizes above the store geometry act as the maximum.
   assign eff_w = (image_width_ff > MAX_W_CFG) ? MAX_W_CFG : image_width_ff;
   assign eff_h = (image_height_ff > MAX_H_CFG) ? MAX_H_CFG : image_height_ff;
   assign oor   = ({1'b0, req_data.column} >= eff_w) || ({1'b0, req_data.row} >= eff_h);
   assign map_start = is_fetch && !oor;

   // Configuration registers; a zero tile factor is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_factor_ff  <= CFG_W'(1);
         image_width_ff  <= MAX_W_CFG;
         image_height_ff <= MAX_H_CFG;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TILE_FACTOR: begin
               if (csr_wdata != '0) begin
                  tile_factor_ff <= csr_wdata;
               end
            end
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Column and row mapping units
   itmm_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (map_start),
      .pos    (req_data.column),
      .size   (eff_w),
      .factor (tile_factor_ff),
      .busy   (x_busy),
      .src    (x_src)
   );

   itmm_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (map_start),
      .pos    (req_data.row),
      .size   (eff_h),
      .factor (tile_factor_ff),
      .busy   (y_busy),
      .src    (y_src)
   );

   // Control sequence for a fetch
   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (is_fetch) begin
               state_in = oor ? T_OUT : T_MAP;
            end
         end
         T_MAP: begin
            if (!x_busy && !y_busy) begin
               rd_en    = 1'b1;
               state_in = T_READ;
            end
         end
         T_READ: begin
            state_in = T_OUT;
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Frame store. Stores are taken only in the idle state and reads happen
   // later in the fetch sequence, so accesses never overlap.
   always_ff @(posedge clock) begin
      if (is_store) begin
         frame_mem[{req_data.row, req_data.column}] <= req_data.pixel_in;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[{y_src, x_src}];
      end
   end

   // Pending result of the current fetch
   always_ff @(posedge clock) begin
      if (is_fetch && oor) begin
         res_pix_ff <= '0;
         res_oor_ff <= 1'b1;
      end else if (state_ff == T_READ) begin
         res_pix_ff <= rd_data_ff;
         res_oor_ff <= 1'b0;
      end
   end

   // Response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.pixel_out    <= res_pix_ff;
         rsp_data_ff.out_of_range <= res_oor_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.out_of_range |-> rsp_data_ff.pixel_out == '0)
      else $error("out-of-range response carries a nonzero pixel");

   a_axes_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_IDLE |-> !x_busy && !y_busy)
      else $error("axis unit busy while the mapper is idle");

   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      is_store && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("store transaction produced a response");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_OUT && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && state_ff == T_IDLE)
      else $error("finished fetch did not reach the response register");

endmodule

`default_nettype wire

// File: bench/mosaic_fetch_checker.sv
// ----------------------------------------------------------------------------
// mosaic_fetch_checker
// Watches the request, response and csr ports of the tile mosaic mapper. It
// keeps its own copy of the frame store and the three registers, works out
// the mosaic pixel for every accepted fetch transaction, and compares each
// response field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module mosaic_fetch_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire  itmm_pkg::itmm_req_type       req_data,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire  itmm_pkg::itmm_rsp_type       rsp_data,
   input  wire                                csr_write,
   input  wire  [itmm_pkg::CSR_A_W-1:0]       csr_index,
   input  wire  [itmm_pkg::CFG_W-1:0]         csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 checked
);

   import itmm_pkg::*;

   // One predicted response with the coordinate that asked for it.
   typedef struct packed {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      itmm_rsp_type     rsp;
   } fetch_outcome_type;

   logic [CFG_W-1:0]  factor_reg;
   logic [CFG_W-1:0]  width_reg;
   logic [CFG_W-1:0]  height_reg;
   logic [PIX_W-1:0]  frame_copy [MEM_DEPTH];
   fetch_outcome_type awaited_fetches [$];

   // Source coordinate along one axis for an output position inside the
   // image. The first tiles are one pixel wider when the factor does not
   // divide the size; a tile one pixel wide always reads its first source.
   function automatic int unsigned source_coordinate(input int unsigned pos,
                                                     input int unsigned extent,
                                                     input int unsigned factor);
      int unsigned wide_span;
      int unsigned wide_count;
      int unsigned narrow_span;
      int unsigned offset;
      wide_span  = (extent + factor - 1) / factor;
      wide_count = extent % factor;
      if (wide_count == 0)
         wide_count = factor;
      if (pos < wide_count * wide_span) begin
         offset = pos % wide_span;
      end else begin
         narrow_span = wide_span - 1;
         offset = (narrow_span == 0) ? 0 : (pos - wide_count * wide_span) % narrow_span;
      end
      return offset * factor;
   endfunction

   // Mosaic pixel for one fetch under the current registers.
   function automatic itmm_rsp_type predict_mosaic_pixel(input itmm_req_type req);
      int unsigned  eff_w;
      int unsigned  eff_h;
      int unsigned  src_x;
      int unsigned  src_y;
      itmm_rsp_type rsp;
      eff_w = (width_reg > MAX_W_CFG) ? MAX_WIDTH : 32'(width_reg);
      eff_h = (height_reg > MAX_H_CFG) ? MAX_HEIGHT : 32'(height_reg);
      if (32'(req.column) >= eff_w || 32'(req.row) >= eff_h) begin
         rsp.pixel_out    = '0;
         rsp.out_of_range = 1'b1;
      end else begin
         src_x = source_coordinate(32'(req.column), eff_w, 32'(factor_reg));
         src_y = source_coordinate(32'(req.row), eff_h, 32'(factor_reg));
         if (src_x >= MAX_WIDTH)
            src_x = MAX_WIDTH - 1;
         if (src_y >= MAX_HEIGHT)
            src_y = MAX_HEIGHT - 1;
         rsp.pixel_out    = frame_copy[ADDR_W'(src_y * MAX_WIDTH + src_x)];
         rsp.out_of_range = 1'b0;
      end
      return rsp;
   endfunction

   // Track register writes, stores and fetches, and score each response.
   always @(posedge clock) begin
      fetch_outcome_type next_fetch;
      fetch_outcome_type oldest;
      if (reset) begin
         factor_reg  = CFG_W'(1);
         width_reg   = MAX_W_CFG;
         height_reg  = MAX_H_CFG;
         mismatches  = 0;
         checked     = 0;
         awaited_fetches.delete();
      end else begin
         // A zero factor and the spare index leave the registers alone.
         if (csr_write) begin
            case (csr_index)
               CSR_TILE_FACTOR: begin
                  if (csr_wdata != '0)
                     factor_reg = csr_wdata;
               end
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end

         // Accepted request transaction.
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_STORE) begin
               frame_copy[{req_data.row, req_data.column}] = req_data.pixel_in;
            end else begin
               next_fetch.column = req_data.column;
               next_fetch.row    = req_data.row;
               next_fetch.rsp    = predict_mosaic_pixel(req_data);
               awaited_fetches.push_back(next_fetch);
            end
         end

         // Accepted response transaction.
         if (rsp_valid && rsp_ready) begin
            if (awaited_fetches.size() == 0) begin
               $display("%0t: response with no fetch outstanding: expected none, got %h/%b",
                        $time, rsp_data.pixel_out, rsp_data.out_of_range);
               mismatches++;
            end else begin
               oldest = awaited_fetches.pop_front();
               checked++;
               if (rsp_data.pixel_out !== oldest.rsp.pixel_out) begin
                  $display("%0t: fetch (%0d,%0d) pixel_out expected %h, got %h", $time,
                           oldest.column, oldest.row, oldest.rsp.pixel_out,
                           rsp_data.pixel_out);
                  mismatches++;
               end
               if (rsp_data.out_of_range !== oldest.rsp.out_of_range) begin
                  $display("%0t: fetch (%0d,%0d) out_of_range expected %b, got %b", $time,
                           oldest.column, oldest.row, oldest.rsp.out_of_range,
                           rsp_data.out_of_range);
                  mismatches++;
               end
            end
         end
      end
      outstanding = awaited_fetches.size();
   end

endmodule

`default_nettype wire

// File: bench/tb_image_tile_mosaic_mapper.sv
// ----------------------------------------------------------------------------
// tb_image_tile_mosaic_mapper
// Stimulus and verdict for the tile mosaic mapper. A short directed part hits
// the register extremes, oversized and zero image sizes, ignored factor and
// spare-index writes, and out-of-range fetches; then fixed and random
// register settings follow, each with its sampled source grid stored first
// and then a mix of stores and fetches with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_image_tile_mosaic_mapper;

   import itmm_pkg::*;

   localparam logic [CSR_A_W-1:0] CSR_SPARE = 2'd3;
   localparam int PHASE_ITEMS  = 55;
   localparam int PHASE_COUNT  = 16;
   localparam int GRID_CAP     = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   itmm_req_type       req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   itmm_rsp_type       rsp_data;
   logic               csr_write = 1'b0;
   logic [CSR_A_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]   csr_wdata = '0;

   int mismatches;
   int outstanding;
   int checked;
   int stores_sent   = 0;
   int fetches_sent  = 0;
   int settings_used = 0;
   bit steady_sender = 1'b0;

   // Effective register values, used only to shape the stimulus.
   int unsigned tiles_n = 1;
   int unsigned span_w  = MAX_WIDTH;
   int unsigned span_h  = MAX_HEIGHT;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   image_tile_mosaic_mapper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mosaic_fetch_checker fetch_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // Offers one request transaction and returns at the falling edge after it
   // is accepted. Valid stays high into the next call when no gap is drawn.
   task automatic send_op(input logic op, input logic [POS_W-1:0] col,
                          input logic [POS_W-1:0] row, input logic [PIX_W-1:0] pix);
      itmm_req_type item;
      int           gap;
      item.opcode   = op;
      item.column   = col;
      item.row      = row;
      item.pixel_in = pix;
      gap = steady_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (op == OP_STORE)
         stores_sent++;
      else
         fetches_sent++;
      @(negedge clock);
   endtask

   // Drops valid and waits until every fetch has answered and any store
   // still in the pipeline has retired.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Single register write; leaves a low cycle so writes never merge.
   task automatic write_register(input logic [CSR_A_W-1:0] index,
                                 input logic [CFG_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      case (index)
         CSR_TILE_FACTOR: begin
            if (value != '0)
               tiles_n = 32'(value);
         end
         CSR_IMAGE_WIDTH:  span_w = (value > MAX_W_CFG) ? MAX_WIDTH : 32'(value);
         CSR_IMAGE_HEIGHT: span_h = (value > MAX_H_CFG) ? MAX_HEIGHT : 32'(value);
         default: ;
      endcase
   endtask

   // New register setting, then store every source pixel the mosaic can
   // read so that no fetch ever touches an unwritten entry.
   task automatic configure(input int unsigned n, input int unsigned w,
                            input int unsigned h);
      int unsigned gx;
      int unsigned gy;
      quiesce();
      write_register(CSR_TILE_FACTOR, CFG_W'(n));
      write_register(CSR_IMAGE_WIDTH, CFG_W'(w));
      write_register(CSR_IMAGE_HEIGHT, CFG_W'(h));
      if ($urandom_range(0, 3) == 0)
         write_register(CSR_TILE_FACTOR, '0);
      settings_used++;
      for (gy = 0; gy * tiles_n < span_h; gy++)
         for (gx = 0; gx * tiles_n < span_w; gx++)
            send_op(OP_STORE, POS_W'(gx * tiles_n), POS_W'(gy * tiles_n), $urandom());
   endtask

   // A coordinate at or next to an image border.
   function automatic logic [POS_W-1:0] border_pick(input int unsigned span);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return POS_W'(span - 1);
         2:       return (span > 255) ? 8'd255 : POS_W'(span);
         default: return 8'd255;
      endcase
   endfunction

   // Receiver: random hold-off per transaction, quiet stretches, and now
   // and then a long stall so the block backs up into the request side.
   initial begin : rsp_side
      int hold;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (taken % 32 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (taken % 500 == 150)
            hold = HOLD_CYCLES;
         else
            hold = steady ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Main stimulus and verdict.
   initial begin : stimulus
      int          phase;
      int          pick;
      int unsigned n;
      int unsigned w;
      int unsigned h;
      int unsigned ew;
      int unsigned eh;
      logic        op;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Largest factor on the full frame: every output pixel is the origin.
      configure(256, 256, 256);
      send_op(OP_STORE, 8'd0, 8'd0, 32'h0000_0000);
      send_op(OP_STORE, 8'd255, 8'd255, 32'hFFFF_FFFF);
      send_op(OP_STORE, 8'd255, 8'd0, 32'hA5A5_5A5A);
      send_op(OP_STORE, 8'd0, 8'd255, 32'h5A5A_A5A5);
      send_op(OP_FETCH, 8'd0, 8'd0, $urandom());
      send_op(OP_FETCH, 8'd255, 8'd255, $urandom());
      send_op(OP_FETCH, 8'd255, 8'd0, $urandom());
      send_op(OP_FETCH, 8'd0, 8'd255, $urandom());

      // Smallest image: one pixel inside, everything else out of range.
      configure(1, 1, 1);
      send_op(OP_FETCH, 8'd0, 8'd0, $urandom());
      send_op(OP_FETCH, 8'd1, 8'd0, $urandom());
      send_op(OP_FETCH, 8'd0, 8'd1, $urandom());
      send_op(OP_FETCH, 8'd255, 8'd255, $urandom());

      // A zero factor is ignored and the factor stays at one.
      quiesce();
      write_register(CSR_TILE_FACTOR, '0);
      send_op(OP_FETCH, 8'd0, 8'd0, $urandom());

      // Sizes above the frame limits act as the limits, here with a factor above them too.
      configure(511, 511, 300);
      send_op(OP_FETCH, 8'd255, 8'd255, $urandom());
      send_op(OP_FETCH, 8'd128, 8'd3, $urandom());

      // A write to the spare index changes nothing.
      quiesce();
      write_register(CSR_SPARE, '1);
      send_op(OP_FETCH, 8'd17, 8'd200, $urandom());

      // Zero height, then zero width: every fetch is out of range.
      configure(2, 4, 0);
      send_op(OP_FETCH, 8'd0, 8'd0, $urandom());
      configure(2, 0, 4);
      send_op(OP_FETCH, 8'd0, 8'd0, $urandom());

      // Factor above the image size: one-pixel tiles and empty ones.
      configure(3, 2, 2);
      send_op(OP_FETCH, 8'd1, 8'd1, $urandom());
      send_op(OP_FETCH, 8'd2, 8'd1, $urandom());

      // Fixed corner settings first, then random ones with a bounded grid.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         case (phase)
            0: configure(32, 256, 256);
            1: configure(7, 100, 60);
            2: configure(6, 50, 40);
            3: configure(300, 256, 10);
            4: configure(29, 200, 255);
            5: configure(256, 1, 256);
            6: configure(1, 12, 9);
            7: configure(5, 0, 40);
            default: begin
               do begin
                  n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 24)
                                                 : $urandom_range(1, 511);
                  pick = $urandom_range(0, 19);
                  w = (pick == 0) ? 0 : (pick < 4) ? $urandom_range(257, 511)
                                                   : $urandom_range(1, 256);
                  pick = $urandom_range(0, 19);
                  h = (pick == 0) ? 0 : (pick < 4) ? $urandom_range(257, 511)
                                                   : $urandom_range(1, 256);
                  ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
                  eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
               end while (((ew + n - 1) / n) * ((eh + n - 1) / n) > GRID_CAP);
               configure(n, w, h);
            end
         endcase

         // Mostly fetches inside the image, some at the borders, some anywhere.
         repeat (PHASE_ITEMS) begin
            op  = ($urandom_range(0, 3) == 0) ? OP_STORE : OP_FETCH;
            col = POS_W'($urandom_range(0, 255));
            row = POS_W'($urandom_range(0, 255));
            if (op == OP_FETCH && span_w > 0 && span_h > 0) begin
               pick = $urandom_range(0, 19);
               if (pick < 14) begin
                  col = POS_W'($urandom_range(0, span_w - 1));
                  row = POS_W'($urandom_range(0, span_h - 1));
               end else if (pick < 17) begin
                  col = border_pick(span_w);
                  row = border_pick(span_h);
               end
            end
            send_op(op, col, row, $urandom());
         end
      end
      steady_sender = 1'b0;

      quiesce();
      $display("Covered %0d stores and %0d fetches across %0d register settings.",
               stores_sent, fetches_sent, settings_used);
      $display("Compared %0d responses, %0d mismatches.", checked, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/itmm_pkg.sv
hw/rtl/itmm_div.sv
hw/rtl/itmm_axis.sv
hw/rtl/image_tile_mosaic_mapper.sv
bench/mosaic_fetch_checker.sv
bench/tb_image_tile_mosaic_mapper.sv
